>>> rtl/core/ps2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2a_pkg
// Shared types, scancode constants and character ROMs for the PS/2 set-1
// scancode decoder.
// ----------------------------------------------------------------------------
package ps2a_pkg;

	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
	localparam logic [7:0] SC_CAPS_LOCK    = 8'h3a;
	localparam logic [7:0] SC_NUM_LOCK     = 8'h45;
	localparam logic [7:0] SC_SCROLL_LOCK  = 8'h46;
	localparam logic [7:0] SC_ACK          = 8'hfa;
	localparam logic [7:0] SC_RESEND       = 8'hfe;
	localparam logic [7:0] CASE_OFFSET     = 8'h20;

	localparam logic [2:0] LED_SCROLL = 3'b001;
	localparam logic [2:0] LED_NUM    = 3'b010;
	localparam logic [2:0] LED_CAPS   = 3'b100;

	localparam logic [7:0] LED_CMD_RESET = 8'hed;

	localparam logic CFG_INITIAL_LEDS = 1'b0;
	localparam logic CFG_LED_COMMAND  = 1'b1;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_SEND = 1'b1;

	// One run of bytes for the keyboard: command byte, then LED byte if it fit.
	typedef struct packed {
		logic [7:0] cmd;
		logic [2:0] leds;
		logic       two;
	} ent_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] shift_n;
		logic [2:0] toggle;
		logic       ack;
		logic       resend;
	} dec_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       ovf;
		logic       last;
	} res_t;

	localparam logic [7:0] ROM_PLAIN [128] = '{
		8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
		8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
	};

	localparam logic [7:0] ROM_SHIFTED [128] = '{
		8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
		8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h08, 8'h00,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
		8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
		8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
	};

endpackage
`default_nettype wire

>>> rtl/core/ps2_scancode_to_ascii_with_leds.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_with_leds
// PS/2 set-1 scancode to ASCII decoder with lock-LED command queue.
// ----------------------------------------------------------------------------
// Path: an accepted input word is registered in the input stage, then its results
// in the output buffer. Throughput: one input word per cycle while the output
// buffer has room; an item with two results takes two output words, one per cycle.
// Reset: control state clears; LEDs and the first two queued bytes are taken
// from the configuration registers when the first word is processed.
module ps2_scancode_to_ascii_with_leds #(
	parameter int QUEUE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] scancode
	input  wire logic        s_axis_tuser,   // [0] cmd
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] value, [8] overflow, [15:9] zero
	output logic             m_axis_tuser,   // [0] kind
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [7:0]  cfg_wdata
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_M1 = CW'(QUEUE_DEPTH - 1);

	// configuration
	logic [2:0] cfg_leds_q;
	logic [7:0] cfg_cmd_q;

	// input stage
	logic       v_s1;
	logic       cmd_s1;
	logic [7:0] code_s1;

	// state
	logic          loaded_q;
	logic [1:0]    shift_q;
	logic [2:0]    leds_q;
	logic          await_q;
	logic [7:0]    sent_q;
	logic [CW-1:0] cnt_q;
	logic          half_q;
	logic          init_q;
	ps2a_pkg::ent_t init_ent_q;

	// output buffer
	ps2a_pkg::res_t res_q [2];
	logic [1:0]     res_n_q;

	// processing
	ps2a_pkg::dec_t dec;
	ps2a_pkg::ent_t eff_init_ent;
	ps2a_pkg::ent_t push_ent;
	ps2a_pkg::ent_t q_head;
	ps2a_pkg::ent_t head;
	ps2a_pkg::res_t new0;
	ps2a_pkg::res_t new1;
	ps2a_pkg::res_t rem0;
	ps2a_pkg::res_t rem1;
	logic [2:0]    eff_leds;
	logic [2:0]    leds_n;
	logic [CW-1:0] eff_cnt;
	logic [CW-1:0] cnt_mid;
	logic          eff_init;
	logic          eff_half;
	logic          has_toggle;
	logic          push_cmd;
	logic          push_led;
	logic          dropped;
	logic          await_mid;
	logic          r_char;
	logic          r_resend;
	logic          r_pop;
	logic          r_fill;
	logic [1:0]    nres;
	logic [7:0]    pop_byte;
	logic          ent_done;
	logic          adv_mem;
	logic          drain;
	logic [1:0]    rem_n;
	logic          go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_leds_q <= 3'b000;
			cfg_cmd_q  <= ps2a_pkg::LED_CMD_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				ps2a_pkg::CFG_INITIAL_LEDS: cfg_leds_q <= cfg_wdata[2:0];
				ps2a_pkg::CFG_LED_COMMAND:  cfg_cmd_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			code_s1 <= s_axis_tdata;
		end
	end

	assign eff_leds     = loaded_q ? leds_q : cfg_leds_q;
	assign eff_cnt      = loaded_q ? cnt_q : CW'(2);
	assign eff_init     = loaded_q ? init_q : 1'b1;
	assign eff_init_ent = loaded_q ? init_ent_q
	                               : ps2a_pkg::ent_t'{cmd: cfg_cmd_q, leds: cfg_leds_q, two: 1'b1};

	ps2a_decode u_decode (
		.code   (code_s1),
		.present(!cmd_s1),
		.shift  (shift_q),
		.caps   (eff_leds[2]),
		.dec    (dec)
	);

	always_comb begin
		leds_n     = eff_leds ^ dec.toggle;
		has_toggle = dec.toggle != 3'b000;
		push_cmd   = has_toggle && (eff_cnt < DEPTH_C);
		push_led   = has_toggle && (eff_cnt < DEPTH_M1);
		dropped    = has_toggle && !push_led;
		cnt_mid    = eff_cnt + CW'(push_cmd) + CW'(push_led);
		push_ent   = '{cmd: cfg_cmd_q, leds: leds_n, two: push_led};
		await_mid  = dec.ack ? 1'b0 : await_q;

		r_char   = dec.ch != 8'h00;
		r_resend = dec.resend && await_q;
		r_pop    = (cnt_mid != '0) && !await_mid && !(r_char && r_resend);
		r_fill   = dropped && !r_char && !r_resend && !r_pop;
		nres     = 2'(r_char) + 2'(r_resend) + 2'(r_pop) + 2'(r_fill);

		// front run: the one just written when the queue is empty, else the start run while pending, else the queue head
		if (eff_cnt == '0) begin
			head     = push_ent;
			eff_half = 1'b0;
		end else if (eff_init) begin
			head     = eff_init_ent;
			eff_half = half_q && loaded_q;
		end else begin
			head     = q_head;
			eff_half = half_q;
		end
		pop_byte = eff_half ? {5'b00000, head.leds} : head.cmd;
		ent_done = eff_half || !head.two;
		adv_mem  = go && r_pop && ent_done && !(eff_init && (eff_cnt != '0));

		new0 = '{kind: ps2a_pkg::KIND_CHAR, value: 8'h00, ovf: dropped, last: nres == 2'd1};
		new1 = '{kind: ps2a_pkg::KIND_SEND, value: pop_byte, ovf: dropped, last: 1'b1};
		if (r_char) begin
			new0.value = dec.ch;
			if (r_resend) begin
				new1.value = sent_q;
			end
		end else if (r_resend) begin
			new0.kind  = ps2a_pkg::KIND_SEND;
			new0.value = sent_q;
		end else if (r_pop) begin
			new0.kind  = ps2a_pkg::KIND_SEND;
			new0.value = pop_byte;
		end

		drain = m_axis_tvalid && m_axis_tready;
		rem_n = res_n_q - 2'(drain);
		rem0  = drain ? res_q[1] : res_q[0];
		rem1  = res_q[1];
		go    = v_s1 && ((3'(rem_n) + 3'(nres)) <= 3'd2);
	end

	ps2a_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (go && push_cmd),
		.push_ent(push_ent),
		.adv     (adv_mem),
		.head    (q_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			shift_q  <= 2'b00;
			leds_q   <= 3'b000;
			await_q  <= 1'b0;
			sent_q   <= 8'h00;
			cnt_q    <= '0;
			half_q   <= 1'b0;
			init_q   <= 1'b0;
		end else if (go) begin
			loaded_q <= 1'b1;
			shift_q  <= dec.shift_n;
			leds_q   <= leds_n;
			await_q  <= r_pop ? 1'b1 : await_mid;
			cnt_q    <= cnt_mid - CW'(r_pop);
			init_q   <= eff_init && !(r_pop && ent_done);
			if (r_pop) begin
				sent_q <= pop_byte;
				half_q <= !ent_done;
			end else begin
				half_q <= eff_half;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !loaded_q) begin
			init_ent_q <= eff_init_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_n_q <= 2'd0;
		end else begin
			res_n_q <= rem_n + (go ? nres : 2'd0);
		end
	end

	always_ff @(posedge clk) begin
		res_q[0] <= (rem_n != 2'd0) ? rem0 : new0;
		res_q[1] <= (rem_n == 2'd2) ? rem1 : ((rem_n == 2'd1) ? new0 : new1);
	end

	assign m_axis_tvalid = res_n_q != 2'd0;
	assign m_axis_tdata  = {7'b0000000, res_q[0].ovf, res_q[0].value};
	assign m_axis_tuser  = res_q[0].kind;
	assign m_axis_tlast  = res_q[0].last;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("queue byte count above depth");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_n_q <= 2'd2)
		else $error("output buffer overrun");

	a_pop_awaits: assert property (@(posedge clk) disable iff (!arst_n)
		go && r_pop |=> await_q)
		else $error("sent byte not awaited");

	a_init_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q && init_q |-> cnt_q != '0)
		else $error("start run pending on empty queue");
`endif

endmodule
`default_nettype wire

>>> rtl/core/ps2a_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2a_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ps2a_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/ps2a_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2a_queue
// Show-ahead queue of keyboard byte runs, built on a registered-read RAM with
// a write-to-read bypass.
// ----------------------------------------------------------------------------
module ps2a_queue #(
	parameter int DEPTH = 32,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ps2a_pkg::ent_t  push_ent,
	input  wire logic            adv,
	output ps2a_pkg::ent_t       head
);

	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam int EW = $bits(ps2a_pkg::ent_t);

	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW-1:0]  rd_next;
	logic           byp_q;
	ps2a_pkg::ent_t byp_ent_q;
	logic [EW-1:0]  rdata;

	assign rd_next = adv ? ((rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1) : rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			byp_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			rd_ptr_q <= rd_next;
			byp_q    <= push && (wr_ptr_q == rd_next);
		end
	end

	always_ff @(posedge clk) begin
		byp_ent_q <= push_ent;
	end

	ps2a_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push),
		.waddr(wr_ptr_q),
		.wdata(push_ent),
		.raddr(rd_next),
		.rdata(rdata)
	);

	assign head = byp_q ? byp_ent_q : ps2a_pkg::ent_t'(rdata);

endmodule
`default_nettype wire

>>> rtl/core/ps2a_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2a_decode
// Scancode classification and character lookup with case folding.
// ----------------------------------------------------------------------------
module ps2a_decode (
	input  wire logic [7:0]   code,
	input  wire logic         present,
	input  wire logic [1:0]   shift,
	input  wire logic         caps,
	output ps2a_pkg::dec_t    dec
);

	logic [7:0] raw;
	logic       is_upper;

	always_comb begin
		raw = 8'h00;
		if (present && !code[7]) begin
			raw = (shift == 2'b00) ? ps2a_pkg::ROM_PLAIN[code[6:0]]
			                       : ps2a_pkg::ROM_SHIFTED[code[6:0]];
		end
		is_upper = (raw >= 8'h41) && (raw <= 8'h5a);
		dec.ch   = (is_upper && (caps == (shift != 2'b00))) ? raw + ps2a_pkg::CASE_OFFSET : raw;

		dec.shift_n = shift;
		dec.toggle  = 3'b000;
		dec.ack     = 1'b0;
		dec.resend  = 1'b0;
		if (present) begin
			case (code)
				ps2a_pkg::SC_LSHIFT_MAKE:  dec.shift_n = shift | 2'b01;
				ps2a_pkg::SC_RSHIFT_MAKE:  dec.shift_n = shift | 2'b10;
				ps2a_pkg::SC_LSHIFT_BREAK: dec.shift_n = shift & 2'b10;
				ps2a_pkg::SC_RSHIFT_BREAK: dec.shift_n = shift & 2'b01;
				ps2a_pkg::SC_CAPS_LOCK:    dec.toggle  = ps2a_pkg::LED_CAPS;
				ps2a_pkg::SC_NUM_LOCK:     dec.toggle  = ps2a_pkg::LED_NUM;
				ps2a_pkg::SC_SCROLL_LOCK:  dec.toggle  = ps2a_pkg::LED_SCROLL;
				ps2a_pkg::SC_ACK:          dec.ack     = 1'b1;
				ps2a_pkg::SC_RESEND:       dec.resend  = 1'b1;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire
